@@ rtl/core/psu_pkg.sv @@
// Package for the PNG scanline unfilter core: sizes, filter codes,
// register indexes, lane control and result types. No dependencies.
`default_nettype none

package psu_pkg;

    localparam int LANES         = 8;
    localparam int ROW_UNITS_MAX = 4096;
    localparam int COL_W         = $clog2(ROW_UNITS_MAX);
    localparam int BPU_W         = 4;
    localparam int UPR_W         = 13;
    localparam int CFG_W         = 13;
    localparam int BYTE_W        = 8;
    localparam int WORD_W        = LANES * BYTE_W;
    localparam int CODE_W        = 8;

    // configuration register indexes
    localparam logic CFG_BYTES_PER_UNIT = 1'b0;
    localparam logic CFG_UNITS_PER_ROW  = 1'b1;

    // highest legal filter code
    localparam logic [CODE_W-1:0] FILTER_CODE_MAX = 8'd4;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } filter_t;

    // per-lane control from the row state
    typedef struct packed {
        filter_t filt;
        logic    active;
    } lane_ctrl_t;

    // one result word
    typedef struct packed {
        logic [WORD_W-1:0] pixel_bytes;
        logic              row_end;
        logic              bad_filter;
    } out_word_t;

    // Paeth predictor on one byte lane
    function automatic logic [BYTE_W-1:0] paeth_pred(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic [BYTE_W:0] pa;
        logic [BYTE_W:0] pb;
        logic [BYTE_W:0] pc;
        logic [BYTE_W:0] ab;
        logic [BYTE_W:0] c2;
        pa = (b > c) ? {1'b0, b - c} : {1'b0, c - b};
        pb = (a > c) ? {1'b0, a - c} : {1'b0, c - a};
        ab = {1'b0, a} + {1'b0, b};
        c2 = {c, 1'b0};
        pc = (ab > c2) ? (ab - c2) : (c2 - ab);
        if (pa <= pb && pa <= pc)
            paeth_pred = a;
        else if (pb <= pc)
            paeth_pred = b;
        else
            paeth_pred = c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/psu_if.sv @@
// Channel interfaces for the unfilter core: filtered input words and
// reconstructed output words. Depends on psu_pkg.
`default_nettype none

interface psu_in_if;
    logic                                valid;
    logic                                ready;
    logic [psu_pkg::WORD_W-1:0]          unit_bytes;
    logic [psu_pkg::CODE_W-1:0]          filter_code;
    logic                                new_image;

    modport source (output valid, output unit_bytes, output filter_code,
                    output new_image, input ready);
    modport sink   (input valid, input unit_bytes, input filter_code,
                    input new_image, output ready);
endinterface

interface psu_out_if;
    logic                                valid;
    logic                                ready;
    logic [psu_pkg::WORD_W-1:0]          pixel_bytes;
    logic                                row_end;
    logic                                bad_filter;

    modport source (output valid, output pixel_bytes, output row_end,
                    output bad_filter, input ready);
    modport sink   (input valid, input pixel_bytes, input row_end,
                    input bad_filter, output ready);
endinterface

`default_nettype wire

@@ rtl/core/png_scanline_unfilter_core.sv @@
// Top level of the PNG scanline unfilter: row state, line store,
// byte lanes and output buffer. Depends on psu_pkg, psu_if, psu_ram, psu_lane.
// Each result is registered in the output register, or in the skid stage while the output stalls.
// Throughput: one word per cycle while din.ready is high; the left-neighbor path is the lane adders.
// One cycle with ready low follows each configuration write (line store prefetch).
// Reset clears row control state and config to defaults; the neighbor words and the line store are not cleared.
`default_nettype none

module png_scanline_unfilter_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    psu_in_if.sink                       din,
    psu_out_if.source                    dout,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_index,
    input  wire logic [psu_pkg::CFG_W-1:0] cfg_data
);
    import psu_pkg::*;

    // configuration
    logic [BPU_W-1:0] bpu_reg;
    logic [UPR_W-1:0] upr_reg;
    logic             cfg_hold_reg;

    // row state
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    filter_t           filt_reg;
    filter_t           filt_next;
    logic              bad_reg;
    logic              bad_next;
    logic              first_reg;
    logic              first_next;
    logic [WORD_W-1:0] left_reg;
    logic [WORD_W-1:0] ul_reg;

    // line store and forwarding
    logic [WORD_W-1:0] ram_rdata;
    logic [COL_W-1:0]  rd_addr;
    logic              byp_reg;
    logic [WORD_W-1:0] byp_data_reg;

    // output buffer
    out_word_t out_reg;
    out_word_t skid_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;

    logic [BPU_W-1:0]  bpu_eff;
    logic [UPR_W-1:0]  upr_eff;
    logic              accept;
    logic              pop;
    logic              col_over;
    logic              col_start;
    logic [COL_W-1:0]  col_eff;
    logic [COL_W-1:0]  col_idle;
    logic              row_first;
    logic              code_bad;
    logic [WORD_W-1:0] a_word;
    logic [WORD_W-1:0] up_word;
    logic [WORD_W-1:0] c_word;
    logic [WORD_W-1:0] res;
    logic              row_end;
    lane_ctrl_t        lane_ctrl [LANES];
    out_word_t         new_word;

    // clamp config into range
    always_comb
    begin
        bpu_eff = bpu_reg;
        if (bpu_reg == '0)
            bpu_eff = BPU_W'(1);
        else if (bpu_reg > BPU_W'(LANES))
            bpu_eff = BPU_W'(LANES);
        upr_eff = upr_reg;
        if (upr_reg == '0)
            upr_eff = UPR_W'(1);
        else if (upr_reg > UPR_W'(ROW_UNITS_MAX))
            upr_eff = UPR_W'(ROW_UNITS_MAX);
    end

    // handshake
    assign din.ready = !skid_valid_reg && !cfg_hold_reg;
    assign accept    = din.valid && din.ready;
    assign pop       = out_valid_reg && dout.ready;

    // column and row decode
    assign col_over  = {1'b0, col_reg} >= upr_eff;
    assign col_idle  = col_over ? '0 : col_reg;
    assign col_start = din.new_image || col_over || (col_reg == '0);
    assign col_eff   = (din.new_image || col_over) ? '0 : col_reg;
    assign row_first = din.new_image || first_reg;
    assign code_bad  = din.filter_code > FILTER_CODE_MAX;
    assign row_end   = ({1'b0, col_eff} == (upr_eff - UPR_W'(1)));

    always_comb
    begin
        if (col_start)
        begin
            bad_next  = code_bad;
            filt_next = code_bad ? FLT_NONE : filter_t'(din.filter_code[2:0]);
        end
        else
        begin
            bad_next  = bad_reg;
            filt_next = filt_reg;
        end
        col_next   = row_end ? '0 : (col_eff + COL_W'(1));
        first_next = row_end ? 1'b0 : row_first;
    end

    // neighbor words
    assign a_word  = col_start ? '0 : left_reg;
    assign up_word = row_first ? '0 : (byp_reg ? byp_data_reg : ram_rdata);
    assign c_word  = (row_first || col_start) ? '0 : ul_reg;

    // prefetch the row above for the next word's column
    assign rd_addr = accept ? col_next : col_idle;

    psu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROW_UNITS_MAX)
    ) u_line_store (
        .clk   (clk),
        .we    (accept),
        .waddr (col_eff),
        .wdata (res),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // byte lanes
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        always_comb
        begin
            lane_ctrl[i].filt   = filt_next;
            lane_ctrl[i].active = BPU_W'(i) < bpu_eff;
        end

        psu_lane u_lane (
            .ctrl (lane_ctrl[i]),
            .x    (din.unit_bytes[BYTE_W*i +: BYTE_W]),
            .a    (a_word[BYTE_W*i +: BYTE_W]),
            .b    (up_word[BYTE_W*i +: BYTE_W]),
            .c    (c_word[BYTE_W*i +: BYTE_W]),
            .y    (res[BYTE_W*i +: BYTE_W])
        );
    end

    // merge lanes and row flags into one word
    always_comb
    begin
        new_word.pixel_bytes = res;
        new_word.row_end     = row_end;
        new_word.bad_filter  = bad_next;
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpu_reg      <= BPU_W'(1);
            upr_reg      <= UPR_W'(1);
            cfg_hold_reg <= 1'b0;
        end
        else
        begin
            cfg_hold_reg <= cfg_we;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BYTES_PER_UNIT: bpu_reg <= cfg_data[BPU_W-1:0];
                    CFG_UNITS_PER_ROW:  upr_reg <= cfg_data[UPR_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    // row control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            filt_reg  <= FLT_NONE;
            bad_reg   <= 1'b0;
            first_reg <= 1'b1;
            byp_reg   <= 1'b0;
        end
        else
        begin
            byp_reg <= accept && (rd_addr == col_eff);
            if (accept)
            begin
                col_reg   <= col_next;
                filt_reg  <= filt_next;
                bad_reg   <= bad_next;
                first_reg <= first_next;
            end
        end
    end

    // neighbor payload
    always_ff @(posedge clk)
    begin
        byp_data_reg <= res;
        if (accept)
        begin
            left_reg <= res;
            ul_reg   <= up_word;
        end
    end

    // output register plus skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
                skid_reg <= new_word;
            else
                out_reg <= new_word;
        end
    end

    assign dout.valid       = out_valid_reg;
    assign dout.pixel_bytes = out_reg.pixel_bytes;
    assign dout.row_end     = out_reg.row_end;
    assign dout.bad_filter  = out_reg.bad_filter;

endmodule

`default_nettype wire

@@ rtl/core/psu_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module psu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/psu_lane.sv @@
// One byte lane of filter reconstruction: prediction from the left,
// upper and upper-left bytes plus the filtered byte. Depends on psu_pkg.
`default_nettype none

module psu_lane (
    input  wire psu_pkg::lane_ctrl_t     ctrl,
    input  wire logic [psu_pkg::BYTE_W-1:0] x,
    input  wire logic [psu_pkg::BYTE_W-1:0] a,
    input  wire logic [psu_pkg::BYTE_W-1:0] b,
    input  wire logic [psu_pkg::BYTE_W-1:0] c,
    output logic      [psu_pkg::BYTE_W-1:0] y
);
    import psu_pkg::*;

    logic [BYTE_W-1:0] pred;
    logic [BYTE_W:0]   sum_ab;

    assign sum_ab = {1'b0, a} + {1'b0, b};

    // predictor select
    always_comb
    begin
        case (ctrl.filt)
            FLT_SUB:   pred = a;
            FLT_UP:    pred = b;
            FLT_AVG:   pred = sum_ab[BYTE_W:1];
            FLT_PAETH: pred = paeth_pred(a, b, c);
            default:   pred = '0;
        endcase
    end

    // unused lanes read as zero
    assign y = ctrl.active ? (x + pred) : '0;

endmodule

`default_nettype wire
